// File: rtl/core/sskb_pkg.sv
// shared types and constants for the stacked stepper tone bank
// no dependencies; imported by every module of the core
package sskb_pkg;

    localparam int DRIVES           = 8;
    localparam int DRIVES_PER_GROUP = 2;
    localparam int GROUPS           = 4;
    localparam int VELOCITY_FULL    = 127;
    localparam int VEL_STEP         = VELOCITY_FULL / DRIVES_PER_GROUP;
    localparam int VISIBLE_DRIVES   = (DRIVES < 8) ? DRIVES : 8;
    localparam int DRIVE_IDX_W      = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HEAD_LIMIT_RESET = 8'd150;

    // raw command codes on the input beat
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_NOTE_ON,
        OP_NOTE_OFF
    } op_kind_t;

    typedef struct packed {
        op_kind_t                      kind;
        logic [1:0]                    group;
        logic [6:0]                    note;
        logic [DRIVES_PER_GROUP-1:0]   play;
        logic [15:0]                   period;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DONE
    } bk_state_t;

endpackage

// File: rtl/core/sskb_front.sv
// front end: takes input beats, decodes the command and the velocity reach
// depends on sskb_pkg
module sskb_front
    import sskb_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  qstat_t      q_stat,
    output logic        q_push,
    output op_t         q_data
);

    logic [1:0]  cmd;
    logic [6:0]  vel;

    assign cmd      = s_tuser;
    assign vel      = s_tdata[15:9];
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;

    always_comb begin
        q_data        = '0;
        q_data.group  = s_tdata[1:0];
        q_data.note   = s_tdata[8:2];
        q_data.period = s_tdata[31:16];
        case (cmd)
            CMD_TICK:     q_data.kind = OP_TICK;
            CMD_NOTE_ON:  q_data.kind = OP_NOTE_ON;
            CMD_NOTE_OFF: q_data.kind = OP_NOTE_OFF;
            default:      q_data.kind = OP_NONE;
        endcase
        // sub-drive i plays once velocity reaches i steps
        for (int i = 0; i < DRIVES_PER_GROUP; i++) begin
            q_data.play[i] = int'(vel) >= VEL_STEP * i;
        end
    end

endmodule

// File: rtl/core/sskb_queue.sv
// short fifo of decoded operations between front and back
// depends on sskb_pkg
module sskb_queue
    import sskb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  op_t    push_data,
    input  logic   pop,
    output op_t    pop_data,
    output qstat_t stat
);

    op_t                mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/sskb_back.sv
// back end: holds the drive state, runs note on/off and walks the drives on a tick
// depends on sskb_pkg
module sskb_back
    import sskb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  max_head,
    input  qstat_t      q_stat,
    input  op_t         q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    bk_state_t              state_reg, state_next;
    op_t                    cur_reg;
    logic [DRIVE_IDX_W-1:0] idx_reg;

    logic [6:0]        group_note_reg [GROUPS];
    logic [6:0]        group_note_next [GROUPS];
    logic [15:0]       period_reg [DRIVES];
    logic [15:0]       period_next [DRIVES];
    logic [15:0]       counter_reg [DRIVES];
    logic [15:0]       counter_next [DRIVES];
    logic [7:0]        head_reg [DRIVES];
    logic [7:0]        head_next [DRIVES];
    logic [DRIVES-1:0] dir_reg, dir_next;
    logic [DRIVES-1:0] step_reg, step_next;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic        out_free;
    logic        exec;
    logic        load_out;
    logic        last_drive;
    logic        note_match;
    logic [7:0]  sel_head, head_moved;
    logic [7:0]  steps, dirs;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_drive = idx_reg == DRIVE_IDX_W'(DRIVES - 1);
    assign note_match = group_note_reg[cur_reg.group] == cur_reg.note;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_EXEC;
            BK_EXEC: if (cur_reg.kind != OP_TICK || last_drive) state_next = BK_DONE;
            BK_DONE: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        exec     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop    = !q_stat.empty;
            BK_EXEC: exec     = 1'b1;
            BK_DONE: load_out = out_free;
            default: ;
        endcase
    end

    // one drive per cycle on a tick
    assign sel_head   = head_reg[idx_reg];
    assign head_moved = dir_reg[idx_reg] ? sel_head - 8'd1 : sel_head + 8'd1;

    always_comb begin
        group_note_next = group_note_reg;
        period_next     = period_reg;
        counter_next    = counter_reg;
        head_next       = head_reg;
        dir_next        = dir_reg;
        step_next       = step_reg;
        if (exec) begin
            case (cur_reg.kind)
                OP_TICK: begin
                    if (period_reg[idx_reg] != '0) begin
                        if (counter_reg[idx_reg] >= period_reg[idx_reg]) begin
                            counter_next[idx_reg] = '0;
                            head_next[idx_reg]    = head_moved;
                            step_next[idx_reg]    = !step_reg[idx_reg];
                            if (head_moved == max_head || head_moved == 8'd0) begin
                                dir_next[idx_reg] = !dir_reg[idx_reg];
                            end
                        end else begin
                            counter_next[idx_reg] = counter_reg[idx_reg] + 16'd1;
                        end
                    end
                end
                OP_NOTE_ON: begin
                    group_note_next[cur_reg.group] = cur_reg.note;
                    for (int d = 0; d < DRIVES; d++) begin
                        if ((d / DRIVES_PER_GROUP) == int'(cur_reg.group) &&
                            cur_reg.play[d % DRIVES_PER_GROUP]) begin
                            period_next[d] = cur_reg.period;
                        end
                    end
                end
                OP_NOTE_OFF: begin
                    // only the note bits are kept, so an idle group matches note zero
                    if (note_match) begin
                        group_note_next[cur_reg.group] = '0;
                        for (int d = 0; d < DRIVES; d++) begin
                            if ((d / DRIVES_PER_GROUP) == int'(cur_reg.group)) begin
                                period_next[d] = '0;
                                step_next[d]   = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        steps = '0;
        dirs  = '0;
        for (int v = 0; v < VISIBLE_DRIVES; v++) begin
            steps[v] = step_reg[v];
            dirs[v]  = dir_reg[v];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (load_out) begin
            m_tdata_reg <= {dirs, steps};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            idx_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            group_note_reg <= '{default: '0};
            period_reg     <= '{default: '0};
            counter_reg    <= '{default: '0};
            head_reg       <= '{default: '0};
            dir_reg        <= '0;
            step_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            group_note_reg <= group_note_next;
            period_reg     <= period_next;
            counter_reg    <= counter_next;
            head_reg       <= head_next;
            dir_reg        <= dir_next;
            step_reg       <= step_next;
            if (q_pop) begin
                idx_reg <= '0;
            end else if (exec && cur_reg.kind == OP_TICK && !last_drive) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/stacked_stepper_tone_bank_core.sv
// Eight stepper drives in four groups of two, played as square-wave tone
// generators. Every input beat returns one output beat with the step and
// direction line levels after that item. On a tick the back end pops the item,
// visits one drive per cycle, then loads the result. Note on, note off and
// the unused command run the same pop, execute and load steps but walk no
// drives. A two-entry queue sits between the decoder and the drive engine, so
// up to two beats are taken while the engine is busy or a result waits.
// max_head_position is written over the cfg channel, which is always ready;
// write it only while no item is in flight.
// top level; depends on sskb_pkg, sskb_front, sskb_queue, sskb_back
module stacked_stepper_tone_bank_core
    import sskb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // group[1:0], note[8:2], velocity[15:9], note_period[31:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // step_lines[7:0], direction_lines[15:8]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // max_head_position[7:0]
);

    logic [7:0] max_head_reg;
    qstat_t     q_stat;
    logic       q_push;
    logic       q_pop;
    op_t        q_in;
    op_t        q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_head_reg <= HEAD_LIMIT_RESET;
        end else if (cfg_valid) begin
            max_head_reg <= cfg_data;
        end
    end

    sskb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sskb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    sskb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .max_head (max_head_reg),
        .q_stat   (q_stat),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_full_empty_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue flags full and empty together");

    a_pop_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_push && q_stat.full) |=> !q_stat.full)
        else $error("queue stays full after a pop");

endmodule
